// ===== rtl/ctks_pkg.sv =====
// Shared types and constants for the cosine top-K search block.
package ctks_pkg;

  // Fixed field widths.
  localparam int VAL_W   = 16;
  localparam int CNT_W   = 9;
  localparam int TOPC_W  = 5;
  localparam int IDX_W   = 16;
  localparam int SCORE_W = 16;
  localparam int STAT_W  = 2;
  localparam int MODE_W  = 2;
  localparam int REG_W   = 1;

  // Arithmetic widths.
  localparam int DOT_W   = 40;
  localparam int NORM_W  = 39;
  localparam int ROOT_W  = 20;
  localparam int SREM_W  = ROOT_W + 3;
  localparam int DEN_W   = 2 * ROOT_W;
  localparam int NUM_W   = DOT_W + 15;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SQ_W    = 2 * VAL_W - 1;
  localparam int STEP_W  = 6;

  // One root digit per step, one quotient bit per step.
  localparam int SQ_STEPS  = ROOT_W;
  localparam int DIV_STEPS = NUM_W;

  localparam logic [CNT_W-1:0] COUNT_SAT = 9'd511;

  // Item modes. The spare code is accepted and ignored.
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DBASE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISMATCH = 2'd2;

  // Register indexes.
  localparam logic [REG_W-1:0] REG_FEATURE_LENGTH = 1'd0;
  localparam logic [REG_W-1:0] REG_TOP_COUNT      = 1'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_q;
    logic take_d;
    logic acc_q;
    logic acc_d;
    logic vec_clear;
    logic sq_load;
    logic sq_sel_d;
    logic sq_step;
    logic save_q;
    logic dmul;
    logic div_load;
    logic div_step;
    logic insert;
    logic rpt_load;
    logic clear;
  } ctks_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pc_ok;
    logic out_free;
    logic rpt_final;
  } ctks_sts_t;

endpackage

// ===== rtl/ctks_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
interface ctks_in_if;
  logic                                valid;
  logic                                ready;
  logic [ctks_pkg::MODE_W-1:0]         mode;
  logic signed [ctks_pkg::VAL_W-1:0]   feature_value;
  logic                                last_element;
  modport source (output valid, mode, feature_value, last_element, input ready);
  modport sink (input valid, mode, feature_value, last_element, output ready);
endinterface

interface ctks_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [ctks_pkg::IDX_W-1:0]           product_index;
  logic signed [ctks_pkg::SCORE_W-1:0]  score;
  logic [ctks_pkg::STAT_W-1:0]          status;
  logic                                 last_result;
  modport source (output valid, product_index, score, status, last_result, input ready);
  modport sink (input valid, product_index, score, status, last_result, output ready);
endinterface

interface ctks_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ctks_pkg::REG_W-1:0]    index;
  logic [ctks_pkg::CNT_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ctks_ctrl.sv =====
// Controller state machine for the cosine top-K search block.
module ctks_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [ctks_pkg::MODE_W-1:0]  in_mode,
  input  logic                         in_last,
  output logic                         in_ready,
  input  ctks_pkg::ctks_sts_t          sts,
  output ctks_pkg::ctks_cmd_t          cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_ACC  = 4'd2;
  localparam logic [3:0] ST_SQQ  = 4'd3;
  localparam logic [3:0] ST_SWAP = 4'd4;
  localparam logic [3:0] ST_SQD  = 4'd5;
  localparam logic [3:0] ST_DMUL = 4'd6;
  localparam logic [3:0] ST_DIVL = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_INS  = 4'd9;
  localparam logic [3:0] ST_RPT  = 4'd10;

  logic [3:0]                   state_r, state_nxt;
  logic [ctks_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         is_query_r, is_query_nxt;
  logic                         last_r, last_nxt;
  logic                         accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    is_query_nxt = is_query_r;
    last_nxt     = last_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          last_nxt = in_last;
          if (in_mode == ctks_pkg::MODE_QUERY) begin
            cmd.take_q   = 1'b1;
            is_query_nxt = 1'b1;
            state_nxt    = ST_MUL;
          end else if (in_mode == ctks_pkg::MODE_DBASE) begin
            cmd.take_d   = 1'b1;
            is_query_nxt = 1'b0;
            state_nxt    = ST_MUL;
          end else if (in_mode == ctks_pkg::MODE_REPORT) begin
            state_nxt = ST_RPT;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        state_nxt = ST_IDLE;
        if (is_query_r) begin
          cmd.acc_q = 1'b1;
        end else if (last_r && !sts.pc_ok) begin
          cmd.vec_clear = 1'b1;
        end else begin
          cmd.acc_d = 1'b1;
          if (last_r) begin
            cmd.sq_load = 1'b1;
            step_nxt    = '0;
            state_nxt   = ST_SQQ;
          end
        end
      end
      ST_SQQ: begin
        cmd.sq_step = 1'b1;
        step_nxt    = step_r + 1'b1;
        if (step_r == ctks_pkg::STEP_W'(ctks_pkg::SQ_STEPS - 1)) begin
          state_nxt = ST_SWAP;
        end
      end
      ST_SWAP: begin
        cmd.save_q   = 1'b1;
        cmd.sq_load  = 1'b1;
        cmd.sq_sel_d = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_SQD;
      end
      ST_SQD: begin
        cmd.sq_step = 1'b1;
        step_nxt    = step_r + 1'b1;
        if (step_r == ctks_pkg::STEP_W'(ctks_pkg::SQ_STEPS - 1)) begin
          state_nxt = ST_DMUL;
        end
      end
      ST_DMUL: begin
        cmd.dmul  = 1'b1;
        state_nxt = ST_DIVL;
      end
      ST_DIVL: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == ctks_pkg::STEP_W'(ctks_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_RPT: begin
        if (sts.out_free) begin
          cmd.rpt_load = 1'b1;
          if (sts.rpt_final) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= '0;
      is_query_r <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      is_query_r <= is_query_nxt;
      last_r     <= last_nxt;
    end
  end

endmodule

// ===== rtl/ctks_dp.sv =====
// Datapath: query memory, accumulators, root and divide units, best list, result register.
module ctks_dp #(
  parameter int MAX_LEN      = 256,
  parameter int K_MAX        = 16,
  parameter int MAX_PRODUCTS = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ctks_pkg::ctks_cmd_t                  cmd,
  output ctks_pkg::ctks_sts_t                  sts,
  input  logic signed [ctks_pkg::VAL_W-1:0]    in_value,
  input  logic                                 in_last,
  input  logic                                 cfg_valid,
  input  logic [ctks_pkg::REG_W-1:0]           cfg_index,
  input  logic [ctks_pkg::CNT_W-1:0]           cfg_data,
  output logic                                 cfg_ready,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [ctks_pkg::IDX_W-1:0]           out_index,
  output logic signed [ctks_pkg::SCORE_W-1:0]  out_score,
  output logic [ctks_pkg::STAT_W-1:0]          out_status,
  output logic                                 out_last
);

  localparam int QA_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int PC_W   = $clog2(MAX_PRODUCTS + 1);
  localparam int FILL_W = $clog2(K_MAX + 1);
  localparam int RI_W   = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  // Registers.
  logic [ctks_pkg::CNT_W-1:0]           flen_r;
  logic [ctks_pkg::TOPC_W-1:0]          topc_r;
  logic signed [ctks_pkg::VAL_W-1:0]    query_mem [MAX_LEN];
  logic signed [ctks_pkg::VAL_W-1:0]    q_rd_r;
  logic                                 qv_ok_r;
  logic signed [ctks_pkg::VAL_W-1:0]    v_r;
  logic signed [ctks_pkg::PROD_W-1:0]   prod_r;
  logic [ctks_pkg::SQ_W-1:0]            sq_r;
  logic [ctks_pkg::CNT_W-1:0]           qcount_r;
  logic                                 qclosed_r;
  logic [ctks_pkg::NORM_W-1:0]          qnorm_r;
  logic [ctks_pkg::CNT_W-1:0]           ecnt_r;
  logic signed [ctks_pkg::DOT_W-1:0]    dot_r;
  logic [ctks_pkg::NORM_W-1:0]          dnorm_r;
  logic [PC_W-1:0]                      pc_r;
  logic                                 len_err_r;
  logic [ctks_pkg::NORM_W:0]            sq_val_r;
  logic [ctks_pkg::SREM_W-1:0]          sq_rem_r;
  logic [ctks_pkg::ROOT_W-1:0]          sq_root_r;
  logic [ctks_pkg::ROOT_W-1:0]          rq_r;
  logic [ctks_pkg::DEN_W-1:0]           den_r;
  logic [ctks_pkg::NUM_W-1:0]           num_r;
  logic [ctks_pkg::DEN_W-1:0]           drem_r;
  logic [ctks_pkg::NUM_W-1:0]           quo_r;
  logic                                 neg_r;
  logic signed [ctks_pkg::SCORE_W-1:0]  best_score_r [K_MAX];
  logic [ctks_pkg::IDX_W-1:0]           best_idx_r [K_MAX];
  logic [FILL_W-1:0]                    fill_r;
  logic [RI_W-1:0]                      rpt_i_r;
  logic                                 out_valid_r;
  logic [ctks_pkg::IDX_W-1:0]           out_index_r;
  logic signed [ctks_pkg::SCORE_W-1:0]  out_score_r;
  logic [ctks_pkg::STAT_W-1:0]          out_status_r;
  logic                                 out_last_r;

  // Combinational signals.
  logic [ctks_pkg::CNT_W-1:0]           widx;
  logic signed [ctks_pkg::VAL_W-1:0]    qv;
  logic signed [ctks_pkg::PROD_W-1:0]   vsq;
  logic [ctks_pkg::SREM_W-1:0]          sq_shift, sq_trial;
  logic [ctks_pkg::DEN_W:0]             div_shift;
  logic [ctks_pkg::DOT_W-1:0]           dot_mag;
  logic signed [ctks_pkg::SCORE_W-1:0]  new_score;
  logic [PC_W+ctks_pkg::IDX_W-1:0]      pc_ext;
  logic [ctks_pkg::IDX_W-1:0]           new_idx;
  logic [K_MAX-1:0]                     ge;
  logic [K_MAX:0]                       ge_ext;
  logic signed [ctks_pkg::SCORE_W-1:0]  ins_score [K_MAX];
  logic [ctks_pkg::IDX_W-1:0]           ins_idx [K_MAX];
  logic [31:0]                          k32, n32;
  logic [ctks_pkg::STAT_W-1:0]          rpt_status;
  logic                                 rpt_final;
  logic                                 sorted_ok;

  assign cfg_ready = 1'b1;

  // Result port outputs come straight from the result register.
  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign out_score  = out_score_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  // Query write slot restarts when a new query begins.
  assign widx = qclosed_r ? '0 : qcount_r;
  assign qv   = qv_ok_r ? q_rd_r : '0;
  assign vsq  = v_r * v_r;

  // Digit-by-digit square root step.
  assign sq_shift = {sq_rem_r[ctks_pkg::SREM_W-3:0],
                     sq_val_r[ctks_pkg::NORM_W:ctks_pkg::NORM_W-1]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};

  // Restoring divide step.
  assign div_shift = {drem_r, num_r[ctks_pkg::NUM_W-1]};
  assign dot_mag   = dot_r[ctks_pkg::DOT_W-1] ? ctks_pkg::DOT_W'(-dot_r) : dot_r;

  // Saturate the truncated quotient to Q1.15.
  always_comb begin
    if (den_r == '0) begin
      new_score = '0;
    end else if (neg_r) begin
      if (quo_r > ctks_pkg::NUM_W'(32768)) begin
        new_score = 16'sh8000;
      end else begin
        new_score = ~quo_r[15:0] + 16'd1;
      end
    end else if (quo_r > ctks_pkg::NUM_W'(32767)) begin
      new_score = 16'sh7fff;
    end else begin
      new_score = quo_r[15:0];
    end
  end

  assign pc_ext  = {{ctks_pkg::IDX_W{1'b0}}, pc_r};
  assign new_idx = pc_ext[ctks_pkg::IDX_W-1:0];

  // Sorted insertion: equal scores stay ahead of the new one.
  always_comb begin
    ge_ext[0] = 1'b1;
    for (int j = 0; j < K_MAX; j++) begin
      ge[j]       = (j < int'(fill_r)) && (best_score_r[j] >= new_score);
      ge_ext[j+1] = ge[j];
    end
    for (int j = 0; j < K_MAX; j++) begin
      if (ge_ext[j+1]) begin
        ins_score[j] = best_score_r[j];
        ins_idx[j]   = best_idx_r[j];
      end else if (ge_ext[j]) begin
        ins_score[j] = new_score;
        ins_idx[j]   = new_idx;
      end else begin
        ins_score[j] = best_score_r[j-1];
        ins_idx[j]   = best_idx_r[j-1];
      end
    end
  end

  // Report count and status.
  always_comb begin
    k32 = (32'(topc_r) < K_MAX) ? 32'(topc_r) : K_MAX;
    n32 = (k32 < 32'(fill_r)) ? k32 : 32'(fill_r);
    if (pc_r == '0 || k32 == 0) begin
      rpt_status = ctks_pkg::STAT_EMPTY;
    end else if (len_err_r || qcount_r != flen_r) begin
      rpt_status = ctks_pkg::STAT_MISMATCH;
    end else begin
      rpt_status = ctks_pkg::STAT_OK;
    end
    rpt_final = (rpt_status != ctks_pkg::STAT_OK) || (32'(rpt_i_r) + 1 == n32);
  end

  assign sts.pc_ok     = 32'(pc_r) < MAX_PRODUCTS;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.rpt_final = rpt_final;

  // Query memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.take_q && 32'(widx) < MAX_LEN) begin
      query_mem[QA_W'(widx)] <= in_value;
    end
    q_rd_r <= query_mem[QA_W'(ecnt_r)];
  end

  // Element products and arithmetic units.
  always_ff @(posedge clk) begin
    if (cmd.take_q || cmd.take_d) begin
      v_r <= in_value;
    end
    prod_r <= qv * v_r;
    sq_r   <= vsq[ctks_pkg::SQ_W-1:0];
    if (cmd.sq_load) begin
      sq_val_r  <= cmd.sq_sel_d ? {1'b0, dnorm_r} : {1'b0, qnorm_r};
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (cmd.sq_step) begin
      sq_val_r <= {sq_val_r[ctks_pkg::NORM_W-2:0], 2'b00};
      if (sq_shift >= sq_trial) begin
        sq_rem_r  <= sq_shift - sq_trial;
        sq_root_r <= {sq_root_r[ctks_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_r  <= sq_shift;
        sq_root_r <= {sq_root_r[ctks_pkg::ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.save_q) begin
      rq_r <= sq_root_r;
    end
    if (cmd.dmul) begin
      den_r <= rq_r * sq_root_r;
    end
    if (cmd.div_load) begin
      num_r  <= {dot_mag, 15'd0};
      neg_r  <= dot_r[ctks_pkg::DOT_W-1];
      drem_r <= '0;
      quo_r  <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[ctks_pkg::NUM_W-2:0], 1'b0};
      if (div_shift >= {1'b0, den_r}) begin
        drem_r <= ctks_pkg::DEN_W'(div_shift - {1'b0, den_r});
        quo_r  <= {quo_r[ctks_pkg::NUM_W-2:0], 1'b1};
      end else begin
        drem_r <= div_shift[ctks_pkg::DEN_W-1:0];
        quo_r  <= {quo_r[ctks_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  // Best list entries.
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int j = 0; j < K_MAX; j++) begin
        best_score_r[j] <= ins_score[j];
        best_idx_r[j]   <= ins_idx[j];
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.rpt_load) begin
      out_status_r <= rpt_status;
      out_last_r   <= rpt_final;
      if (rpt_status == ctks_pkg::STAT_OK) begin
        out_index_r <= best_idx_r[rpt_i_r];
        out_score_r <= best_score_r[rpt_i_r];
      end else begin
        out_index_r <= '0;
        out_score_r <= '0;
      end
    end
  end

  // Control and accumulator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flen_r      <= 9'd256;
      topc_r      <= 5'd1;
      qv_ok_r     <= 1'b0;
      qcount_r    <= '0;
      qclosed_r   <= 1'b0;
      qnorm_r     <= '0;
      ecnt_r      <= '0;
      dot_r       <= '0;
      dnorm_r     <= '0;
      pc_r        <= '0;
      len_err_r   <= 1'b0;
      fill_r      <= '0;
      rpt_i_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          ctks_pkg::REG_FEATURE_LENGTH: flen_r <= cfg_data;
          ctks_pkg::REG_TOP_COUNT:      topc_r <= cfg_data[ctks_pkg::TOPC_W-1:0];
          default: ;
        endcase
      end
      // Query element bookkeeping.
      if (cmd.take_q) begin
        qcount_r  <= (widx < ctks_pkg::COUNT_SAT) ? widx + 1'b1 : widx;
        qclosed_r <= in_last;
        if (qclosed_r) begin
          qnorm_r <= '0;
        end
      end
      if (cmd.acc_q) begin
        qnorm_r <= qnorm_r + ctks_pkg::NORM_W'(sq_r);
      end
      // Database element bookkeeping.
      if (cmd.take_d) begin
        qv_ok_r <= (ecnt_r < qcount_r) && (32'(ecnt_r) < MAX_LEN);
        if (ecnt_r < ctks_pkg::COUNT_SAT) begin
          ecnt_r <= ecnt_r + 1'b1;
        end
      end
      if (cmd.acc_d) begin
        dot_r   <= dot_r + ctks_pkg::DOT_W'(prod_r);
        dnorm_r <= dnorm_r + ctks_pkg::NORM_W'(sq_r);
      end
      if (cmd.vec_clear || cmd.insert) begin
        ecnt_r  <= '0;
        dot_r   <= '0;
        dnorm_r <= '0;
      end
      if (cmd.insert) begin
        pc_r <= pc_r + 1'b1;
        if (ecnt_r != flen_r) begin
          len_err_r <= 1'b1;
        end
        if (32'(fill_r) < K_MAX) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      // Result handshake.
      if (cmd.rpt_load) begin
        out_valid_r <= 1'b1;
        rpt_i_r     <= rpt_i_r + 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.clear) begin
        qcount_r  <= '0;
        qclosed_r <= 1'b0;
        qnorm_r   <= '0;
        ecnt_r    <= '0;
        dot_r     <= '0;
        dnorm_r   <= '0;
        pc_r      <= '0;
        len_err_r <= 1'b0;
        fill_r    <= '0;
        rpt_i_r   <= '0;
      end
    end
  end

  // List order check over the filled entries.
  always_comb begin
    sorted_ok = 1'b1;
    for (int j = 1; j < K_MAX; j++) begin
      if (j < int'(fill_r) && best_score_r[j-1] < best_score_r[j]) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= K_MAX)
    else $error("best list fill exceeds its depth");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    sorted_ok)
    else $error("best list is out of order");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (pc_r == '0) && (fill_r == '0) && !len_err_r)
    else $error("state not cleared after a report");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rpt_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while full");

endmodule

// ===== rtl/cosine_top_k_search.sv =====
// Top level of the cosine-similarity top-K search block.
// Query elements (mode 0) and database elements that do not close a vector (mode 1)
// pass through memory read, multiply and accumulate. The last element of a database
// vector, while fewer than MAX_PRODUCTS vectors have been scored, then runs the shared
// bit-serial root unit (2 x 20 steps, one per vector norm) and the restoring divider
// (55 steps, one quotient bit a cycle), then the sorted insert. A report item
// returns one result word per cycle while the sink is ready and clears the
// search state with its final word; the next item is taken while that word waits.
module cosine_top_k_search #(
  parameter int MAX_LEN      = 256,
  parameter int K_MAX        = 16,
  parameter int MAX_PRODUCTS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  ctks_in_if.sink     in_s,
  ctks_out_if.source  out_s,
  ctks_cfg_if.sink    cfg_s
);

  ctks_pkg::ctks_cmd_t cmd;
  ctks_pkg::ctks_sts_t sts;
  logic                in_ready;

  assign in_s.ready = in_ready;

  // Sequencer.
  ctks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_mode  (in_s.mode),
    .in_last  (in_s.last_element),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic, storage and result register.
  ctks_dp #(
    .MAX_LEN      (MAX_LEN),
    .K_MAX        (K_MAX),
    .MAX_PRODUCTS (MAX_PRODUCTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (in_s.feature_value),
    .in_last    (in_s.last_element),
    .cfg_valid  (cfg_s.valid),
    .cfg_index  (cfg_s.index),
    .cfg_data   (cfg_s.data),
    .cfg_ready  (cfg_s.ready),
    .out_ready  (out_s.ready),
    .out_valid  (out_s.valid),
    .out_index  (out_s.product_index),
    .out_score  (out_s.score),
    .out_status (out_s.status),
    .out_last   (out_s.last_result)
  );

endmodule
